[design/dpr_pkg.sv]
// ----------------------------------------------------------------------------
// dpr_pkg
// Types and constants shared by the ptr reply parser and its checker.
// ----------------------------------------------------------------------------
package dpr_pkg;

    // input beat: one reply byte
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } t_in_beat;

    // output beat: a name character or the closing status
    typedef struct packed {
        logic       result_kind;
        logic [7:0] name_char;
        logic [1:0] status;
        logic       last;
    } t_out_beat;

    // configuration register indexes
    localparam logic CFG_EXPECTED_ID = 1'b0;
    localparam logic CFG_NAME_BUF_SZ = 1'b1;

    // result kinds
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [1:0] ST_SHORT    = 2'd0;
    localparam logic [1:0] ST_NONAME   = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // parse phases
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_QNAME   = 4'd1;
    localparam logic [3:0] PH_QFIXED  = 4'd2;
    localparam logic [3:0] PH_AFIRST  = 4'd3;
    localparam logic [3:0] PH_ALABELS = 4'd4;
    localparam logic [3:0] PH_APTR2   = 4'd5;
    localparam logic [3:0] PH_FIXED   = 4'd6;
    localparam logic [3:0] PH_DATA    = 4'd7;
    localparam logic [3:0] PH_BADREC  = 4'd8;
    localparam logic [3:0] PH_SINK    = 4'd9;

    // copy modes of the rdata name
    localparam logic [1:0] CM_SKIP = 2'd0;
    localparam logic [1:0] CM_COPY = 2'd1;
    localparam logic [1:0] CM_DONE = 2'd2;

    // header byte positions
    localparam int HDR_ID_HI  = 0;
    localparam int HDR_ID_LO  = 1;
    localparam int HDR_QD_HI  = 4;
    localparam int HDR_QD_LO  = 5;
    localparam int HDR_AN_HI  = 6;
    localparam int HDR_AN_LO  = 7;
    localparam int HDR_LAST   = 11;

    // fixed answer fields: type, class, ttl, rdlength
    localparam logic [15:0] FIX_TYPE_HI  = 16'd0;
    localparam logic [15:0] FIX_TYPE_LO  = 16'd1;
    localparam logic [15:0] FIX_CLASS_HI = 16'd2;
    localparam logic [15:0] FIX_CLASS_LO = 16'd3;
    localparam logic [15:0] FIX_RDLEN_HI = 16'd8;
    localparam logic [15:0] FIX_RDLEN_LO = 16'd9;
    localparam logic [15:0] FIX_LEN      = 16'd10;
    localparam logic [15:0] QFIXED_LEN   = 16'd4;

    localparam logic [15:0] RR_TYPE_PTR = 16'd12;
    localparam logic [15:0] RR_CLASS_IN = 16'd1;
    localparam logic [7:0]  PTR_MASK    = 8'hC0;
    localparam logic [7:0]  CHR_DASH    = 8'h2D;
    localparam logic [7:0]  CHR_DOT     = 8'h2E;

    localparam logic [9:0]  NAME_BUF_RST = 10'd256;
    localparam logic [9:0]  NAME_LEN_MAX = 10'd1023;
    localparam logic [15:0] LEAD_LEN_MAX = 16'hFFFF;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    function automatic logic is_alnum(input logic [7:0] b);
        is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                   (b >= 8'h61 && b <= 8'h7A);
    endfunction

endpackage

[design/dns_ptr_response_parser.sv]
// ----------------------------------------------------------------------------
// dns_ptr_response_parser
// Byte-wide dns reply parser that streams out the ptr name of the first answer.
// ----------------------------------------------------------------------------
// usage
//   input channel: one reply byte per beat, last_byte set on the final byte
//   output channel: name characters (result_kind 0) as the rdata arrives, then
//     one status beat (result_kind 1, last 1) per message; the consumer keeps
//     the characters only when that status is resolved (2)
//   config port: write expected_id (index 0) and name_buffer_size (index 1)
//     only while the block is idle
//   throughput: one byte per cycle while o_in_stall is low; a byte that
//     makes both a character and the status puts two beats in the output
//     queue, which drains one a cycle while i_out_stall is low; the queue
//     holds four beats; o_in_stall rises when fewer than two slots are free,
//     so a stalled receiver backs up into the input side
//   reset (synchronous, active low) empties the queue, returns the parser to
//     the header, sets expected_id to 0 and name_buffer_size to 256
//   bytes at position MSG_MAX and beyond are dropped, but their last mark
//     still closes the message
// ----------------------------------------------------------------------------
module dns_ptr_response_parser
    import dpr_pkg::*;
#(
    parameter int MSG_MAX = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write port
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_beat  o_out_data
);

    localparam int POS_W = $clog2(MSG_MAX + 1);

    // config registers
    logic [15:0] r_expected_id;
    logic [9:0]  r_name_buf_sz;

    // parse state
    logic [3:0]       r_phase,       n_phase;
    logic [POS_W-1:0] r_pos,         n_pos;
    logic             r_id_match,    n_id_match;
    logic [15:0]      r_qd_left,     n_qd_left;
    logic             r_an_present,  n_an_present;
    logic [15:0]      r_skip,        n_skip;
    logic [15:0]      r_rr_type,     n_rr_type;
    logic [15:0]      r_rr_class,    n_rr_class;
    logic [15:0]      r_budget,      n_budget;
    logic [9:0]       r_name_len,    n_name_len;
    logic [1:0]       r_copy_mode,   n_copy_mode;
    logic [15:0]      r_lead_len,    n_lead_len;
    logic             r_lead_closed, n_lead_closed;

    // output queue
    t_out_beat        r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wptr, r_rptr;
    logic [OQ_CW-1:0] r_count;

    logic       in_acc;
    logic       pos_live;
    logic       emit_char;
    logic [7:0] char_val;
    logic [1:0] fin_status;
    logic       oq_pop;
    t_out_beat  char_beat, stat_beat;

    wire [7:0] b   = i_in_data.msg_byte;
    wire       fin = i_in_data.last_byte;

    // take a beat only while two queue slots are free
    assign o_in_stall = (r_count > OQ_CW'(OQ_DEPTH - 2));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pos_live   = (r_pos < POS_W'(MSG_MAX));

    // ------------------------------------------------------------------
    // parse step: next state, character and status for the beat at hand
    // ------------------------------------------------------------------
    always_comb begin
        logic go_data;
        logic alnum_b;
        logic copy_now;

        n_phase       = r_phase;
        n_pos         = r_pos;
        n_id_match    = r_id_match;
        n_qd_left     = r_qd_left;
        n_an_present  = r_an_present;
        n_skip        = r_skip;
        n_rr_type     = r_rr_type;
        n_rr_class    = r_rr_class;
        n_budget      = r_budget;
        n_name_len    = r_name_len;
        n_copy_mode   = r_copy_mode;
        n_lead_len    = r_lead_len;
        n_lead_closed = r_lead_closed;
        emit_char     = 1'b0;
        char_val      = b;
        go_data       = 1'b0;
        alnum_b       = is_alnum(b);
        copy_now      = 1'b0;

        if (in_acc && pos_live) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(HDR_ID_HI)) n_skip = {8'h00, b};
                    if (r_pos == POS_W'(HDR_ID_LO))
                        n_id_match = ({r_skip[7:0], b} == r_expected_id);
                    if (r_pos == POS_W'(HDR_QD_HI)) n_qd_left = {b, 8'h00};
                    if (r_pos == POS_W'(HDR_QD_LO)) n_qd_left = {r_qd_left[15:8], b};
                    if (r_pos == POS_W'(HDR_AN_HI) || r_pos == POS_W'(HDR_AN_LO))
                        n_an_present = r_an_present || (b != 8'h00);
                    if (r_pos == POS_W'(HDR_LAST)) begin
                        n_skip = '0;
                        if (!r_id_match || !r_an_present)
                            n_phase = PH_SINK;
                        else if (r_qd_left != 16'd0)
                            n_phase = PH_QNAME;
                        else
                            n_phase = PH_AFIRST;
                    end
                end
                PH_QNAME: begin
                    if (b == 8'h00) begin
                        n_phase = PH_QFIXED;
                        n_skip  = QFIXED_LEN;
                    end
                end
                PH_QFIXED: begin
                    if (r_skip != 16'd0) n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_qd_left = r_qd_left - 16'd1;
                        n_phase   = (n_qd_left != 16'd0) ? PH_QNAME : PH_AFIRST;
                    end
                end
                PH_AFIRST: begin
                    n_skip = '0;
                    if ((b & PTR_MASK) == PTR_MASK) n_phase = PH_APTR2;
                    else if (b == 8'h00)            n_phase = PH_FIXED;
                    else                            n_phase = PH_ALABELS;
                end
                PH_ALABELS: begin
                    if (b == 8'h00) n_phase = PH_FIXED;
                end
                PH_APTR2: begin
                    n_phase = PH_FIXED;
                end
                PH_FIXED: begin
                    if (r_skip < FIX_LEN) begin
                        if (r_skip == FIX_TYPE_HI)  n_rr_type  = {b, 8'h00};
                        if (r_skip == FIX_TYPE_LO)  n_rr_type  = {r_rr_type[15:8], b};
                        if (r_skip == FIX_CLASS_HI) n_rr_class = {b, 8'h00};
                        if (r_skip == FIX_CLASS_LO) n_rr_class = {r_rr_class[15:8], b};
                        if (r_skip == FIX_RDLEN_HI) n_budget   = {b, 8'h00};
                        if (r_skip == FIX_RDLEN_LO) n_budget   = {r_budget[15:8], b};
                        n_skip = r_skip + 16'd1;
                    end else if (r_rr_type != RR_TYPE_PTR || r_rr_class != RR_CLASS_IN) begin
                        n_phase = PH_BADREC;
                    end else begin
                        // first rdata byte: arm the name copy
                        n_phase       = PH_DATA;
                        n_skip        = r_budget;
                        n_copy_mode   = CM_SKIP;
                        n_name_len    = '0;
                        n_lead_len    = '0;
                        n_lead_closed = 1'b0;
                        go_data       = 1'b1;
                    end
                end
                PH_DATA: begin
                    go_data = 1'b1;
                end
                default: begin
                end
            endcase

            // rdata byte: count down, track lead length, form the name
            if (go_data) begin
                if (n_skip != 16'd0) n_skip = n_skip - 16'd1;
                if (!n_lead_closed) begin
                    if (b == 8'h00)                    n_lead_closed = 1'b1;
                    else if (n_lead_len < LEAD_LEN_MAX) n_lead_len = n_lead_len + 16'd1;
                end
                if (n_copy_mode == CM_SKIP) begin
                    if (!alnum_b) begin
                        n_budget = n_budget - 16'd1;
                    end else begin
                        n_copy_mode = CM_COPY;
                        copy_now    = 1'b1;
                    end
                end else if (n_copy_mode == CM_COPY) begin
                    copy_now = 1'b1;
                end
                if (copy_now) begin
                    if (b == 8'h00) begin
                        n_copy_mode = CM_DONE;
                    end else begin
                        emit_char = 1'b1;
                        if (n_budget != 16'd0) begin
                            // separators become dots while the budget lasts
                            if (!alnum_b && b != CHR_DASH) char_val = CHR_DOT;
                            n_budget = n_budget - 16'd1;
                        end
                        if (n_name_len < NAME_LEN_MAX) n_name_len = n_name_len + 10'd1;
                    end
                end
            end
        end

        // status from the state after this byte
        case (n_phase)
            PH_HEADER: fin_status = ST_SHORT;
            PH_SINK:   fin_status = n_id_match ? ST_NONAME : ST_SHORT;
            PH_BADREC: fin_status = ST_REJECT;
            PH_DATA: begin
                if (n_skip != 16'd0)
                    fin_status = ST_REJECT;
                else if ({1'b0, n_lead_len} + 17'd1 > {7'd0, r_name_buf_sz})
                    fin_status = ST_REJECT;
                else if ({1'b0, n_name_len} + 11'd1 > {1'b0, r_name_buf_sz})
                    fin_status = ST_REJECT;
                else
                    fin_status = ST_RESOLVED;
            end
            default:   fin_status = ST_NONAME;
        endcase

        // end of message: parser goes back to its reset state
        if (in_acc && fin) begin
            n_phase       = PH_HEADER;
            n_pos         = '0;
            n_id_match    = 1'b0;
            n_qd_left     = '0;
            n_an_present  = 1'b0;
            n_skip        = '0;
            n_rr_type     = '0;
            n_rr_class    = '0;
            n_budget      = '0;
            n_name_len    = '0;
            n_copy_mode   = CM_SKIP;
            n_lead_len    = '0;
            n_lead_closed = 1'b0;
        end
    end

    always_comb begin
        char_beat             = '0;
        char_beat.result_kind = KIND_CHAR;
        char_beat.name_char   = char_val;
        stat_beat             = '0;
        stat_beat.result_kind = KIND_STATUS;
        stat_beat.status      = fin_status;
        stat_beat.last        = 1'b1;
    end

    // ------------------------------------------------------------------
    // config and parse state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_name_buf_sz <= NAME_BUF_RST;
            r_phase       <= PH_HEADER;
            r_pos         <= '0;
            r_id_match    <= 1'b0;
            r_qd_left     <= '0;
            r_an_present  <= 1'b0;
            r_skip        <= '0;
            r_rr_type     <= '0;
            r_rr_class    <= '0;
            r_budget      <= '0;
            r_name_len    <= '0;
            r_copy_mode   <= CM_SKIP;
            r_lead_len    <= '0;
            r_lead_closed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXPECTED_ID: r_expected_id <= i_cfg_data;
                    CFG_NAME_BUF_SZ: r_name_buf_sz <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_id_match    <= n_id_match;
            r_qd_left     <= n_qd_left;
            r_an_present  <= n_an_present;
            r_skip        <= n_skip;
            r_rr_type     <= n_rr_type;
            r_rr_class    <= n_rr_class;
            r_budget      <= n_budget;
            r_name_len    <= n_name_len;
            r_copy_mode   <= n_copy_mode;
            r_lead_len    <= n_lead_len;
            r_lead_closed <= n_lead_closed;
        end
    end

    // ------------------------------------------------------------------
    // output queue: up to two pushes and one pop per cycle
    // ------------------------------------------------------------------
    logic [1:0] push_n;

    assign oq_pop = (r_count != '0) && !i_out_stall;
    assign push_n = in_acc ? ({1'b0, emit_char} + {1'b0, fin}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (in_acc && emit_char) begin
            r_oq[r_wptr] <= char_beat;
            if (fin) r_oq[r_wptr + OQ_AW'(1)] <= stat_beat;
        end else if (in_acc && fin) begin
            r_oq[r_wptr] <= stat_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + OQ_AW'(push_n);
            if (oq_pop) r_rptr <= r_rptr + OQ_AW'(1);
            r_count <= r_count + OQ_CW'(push_n) - OQ_CW'(oq_pop);
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_oq[r_rptr];

endmodule

[design/dpr_checker.sv]
// ----------------------------------------------------------------------------
// dpr_checker
// Port-level assertions for the ptr reply parser, bound to its top level.
// ----------------------------------------------------------------------------
module dpr_checker
    import dpr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // reset leaves no beat on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat right after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // character beats carry no status and never close a message
    a_char_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_CHAR
            |-> !o_out_data.last && o_out_data.status == ST_SHORT)
        else $error("malformed character beat");

    // status beats close the message and carry no character
    a_stat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_STATUS
            |-> o_out_data.last && o_out_data.name_char == 8'h00)
        else $error("malformed status beat");

    // a final byte always leaves something queued for the receiver
    a_fin_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_byte |=> o_out_valid)
        else $error("final byte gave no output");

endmodule

bind dns_ptr_response_parser dpr_checker u_dpr_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dns ptr reply parser: replies are fed a byte
// per beat and every output beat is compared with a cycle-free parser mirror.
// ----------------------------------------------------------------------------
module testbench;
    import dpr_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int MSG_LIMIT       = 512;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASE_BYTES     = 100;
    localparam int QUIET_CYCLES    = 4;

    typedef enum logic [1:0] {AN_POINTER, AN_LABELS, AN_ROOT} t_answer_form;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_EXPECTED_ID;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        i_in_valid = 1'b0;
    t_in_beat    i_in_data  = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_beat   o_out_data;

    always #HALF_PERIOD i_clk = ~i_clk;

    dns_ptr_response_parser #(
        .MSG_MAX (MSG_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------------
    // bench bookkeeping
    // ------------------------------------------------------------------------
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // name characters and closing statuses still owed by the block, in order
    t_out_beat   decoded_beats[$];

    // reply under construction and the rdata that goes into its answer
    logic [7:0]  reply_bytes[$];
    logic [7:0]  rdata_bytes[$];

    // ------------------------------------------------------------------------
    // parser mirror: register copies and per-message parse state
    // ------------------------------------------------------------------------
    logic [15:0] cfg_id        = 16'h0000;
    logic [9:0]  cfg_name_room = NAME_BUF_RST;

    logic [3:0]  par_phase;
    logic [9:0]  par_pos;
    logic        par_id_ok;
    logic [7:0]  par_id_hi;
    logic [15:0] par_qd_left;
    logic        par_has_an;
    logic [15:0] par_count;
    logic [15:0] par_rtype;
    logic [15:0] par_rclass;
    logic [15:0] par_budget;
    logic [9:0]  par_name_len;
    logic [1:0]  par_copy;
    logic [15:0] par_lead_len;
    logic        par_lead_done;

    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic void reset_parser_mirror();
        par_phase     = PH_HEADER;
        par_pos       = '0;
        par_id_ok     = 1'b0;
        par_id_hi     = '0;
        par_qd_left   = '0;
        par_has_an    = 1'b0;
        par_count     = '0;
        par_rtype     = '0;
        par_rclass    = '0;
        par_budget    = '0;
        par_name_len  = '0;
        par_copy      = CM_SKIP;
        par_lead_len  = '0;
        par_lead_done = 1'b0;
    endfunction

    // one rdata byte: leading junk is dropped, then the name streams out
    function automatic logic take_rdata_byte(input logic [7:0] b, output logic [7:0] ch);
        ch = b;
        if (par_count != 0) par_count--;
        // leading run up to the first zero byte is what the buffer must hold
        if (!par_lead_done) begin
            if (b == 8'h00) par_lead_done = 1'b1;
            else if (par_lead_len != LEAD_LEN_MAX) par_lead_len++;
        end
        if (par_copy == CM_SKIP) begin
            if (!is_name_char(b)) begin
                par_budget--;
                return 1'b0;
            end
            par_copy = CM_COPY;
        end
        if (par_copy != CM_COPY) return 1'b0;
        if (b == 8'h00) begin
            par_copy = CM_DONE;
            return 1'b0;
        end
        // separators become dots only while rdlength lasts
        if (par_budget != 0) begin
            if (!is_name_char(b) && b != CHR_DASH) ch = CHR_DOT;
            par_budget--;
        end
        if (par_name_len != NAME_LEN_MAX) par_name_len++;
        return 1'b1;
    endfunction

    function automatic logic step_parser(input logic [7:0] b, output logic [7:0] ch);
        ch = 8'h00;
        case (par_phase)
            PH_HEADER: begin
                if (par_pos == HDR_ID_HI) par_id_hi = b;
                if (par_pos == HDR_ID_LO) par_id_ok = ({par_id_hi, b} == cfg_id);
                if (par_pos == HDR_QD_HI) par_qd_left = {b, 8'h00};
                if (par_pos == HDR_QD_LO) par_qd_left[7:0] = b;
                if (par_pos == HDR_AN_HI || par_pos == HDR_AN_LO) begin
                    par_has_an = par_has_an || (b != 8'h00);
                end
                if (par_pos == HDR_LAST) begin
                    par_count = '0;
                    if (!par_id_ok || !par_has_an) par_phase = PH_SINK;
                    else par_phase = (par_qd_left != 0) ? PH_QNAME : PH_AFIRST;
                end
                return 1'b0;
            end
            PH_QNAME: begin
                if (b == 8'h00) begin
                    par_phase = PH_QFIXED;
                    par_count = QFIXED_LEN;
                end
                return 1'b0;
            end
            PH_QFIXED: begin
                if (par_count != 0) par_count--;
                if (par_count == 0) begin
                    par_qd_left--;
                    par_phase = (par_qd_left != 0) ? PH_QNAME : PH_AFIRST;
                end
                return 1'b0;
            end
            PH_AFIRST: begin
                par_count = '0;
                if ((b & PTR_MASK) == PTR_MASK) par_phase = PH_APTR2;
                else if (b == 8'h00) par_phase = PH_FIXED;
                else par_phase = PH_ALABELS;
                return 1'b0;
            end
            PH_ALABELS: begin
                if (b == 8'h00) par_phase = PH_FIXED;
                return 1'b0;
            end
            PH_APTR2: begin
                par_phase = PH_FIXED;
                return 1'b0;
            end
            PH_FIXED: begin
                if (par_count < FIX_LEN) begin
                    case (par_count)
                        FIX_TYPE_HI:  par_rtype = {b, 8'h00};
                        FIX_TYPE_LO:  par_rtype[7:0] = b;
                        FIX_CLASS_HI: par_rclass = {b, 8'h00};
                        FIX_CLASS_LO: par_rclass[7:0] = b;
                        FIX_RDLEN_HI: par_budget = {b, 8'h00};
                        FIX_RDLEN_LO: par_budget[7:0] = b;
                        default: ;
                    endcase
                    par_count++;
                    return 1'b0;
                end
                // the record kind is judged on the first rdata byte
                if (par_rtype != RR_TYPE_PTR || par_rclass != RR_CLASS_IN) begin
                    par_phase = PH_BADREC;
                    return 1'b0;
                end
                par_phase     = PH_DATA;
                par_count     = par_budget;
                par_copy      = CM_SKIP;
                par_name_len  = '0;
                par_lead_len  = '0;
                par_lead_done = 1'b0;
                return take_rdata_byte(b, ch);
            end
            PH_DATA: return take_rdata_byte(b, ch);
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [1:0] closing_status();
        case (par_phase)
            PH_HEADER: return ST_SHORT;
            PH_SINK:   return par_id_ok ? ST_NONAME : ST_SHORT;
            PH_BADREC: return ST_REJECT;
            PH_DATA: begin
                if (par_count != 0) return ST_REJECT;
                if (int'(par_lead_len) + 1 > int'(cfg_name_room)) return ST_REJECT;
                if (int'(par_name_len) + 1 > int'(cfg_name_room)) return ST_REJECT;
                return ST_RESOLVED;
            end
            default: return ST_NONAME;
        endcase
    endfunction

    // turns one accepted byte beat into the output beats it owes
    function automatic void parse_reply_byte(input logic [7:0] b, input logic fin);
        logic [7:0] ch;
        t_out_beat  beat;
        if (par_pos < MSG_LIMIT) begin
            if (step_parser(b, ch)) begin
                beat.result_kind = KIND_CHAR;
                beat.name_char   = ch;
                beat.status      = '0;
                beat.last        = 1'b0;
                decoded_beats.push_back(beat);
            end
            par_pos++;
        end
        // the last mark closes the message even past the byte limit
        if (fin) begin
            beat.result_kind = KIND_STATUS;
            beat.name_char   = 8'h00;
            beat.status      = closing_status();
            beat.last        = 1'b1;
            decoded_beats.push_back(beat);
            reset_parser_mirror();
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", what, got, want));
    endtask

    task automatic compare_out_beat(input t_out_beat got);
        t_out_beat want;
        if (decoded_beats.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat kind %0d char %02h status %0d last %0d",
                got.result_kind, got.name_char, got.status, got.last));
            return;
        end
        want = decoded_beats.pop_front();
        check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        check_field("name_char", 32'(got.name_char), 32'(want.name_char));
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("last", 32'(got.last), 32'(want.last));
    endtask

    // output beats are taken at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) compare_out_beat(o_out_data);
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on a hung handshake or a missing beat
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving: called and returning at the falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        t_in_beat beat;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        beat.msg_byte  = b;
        beat.last_byte = fin;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_reply_byte(b, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_reply();
        int k;
        for (k = 0; k < reply_bytes.size(); k++) begin
            send_byte(reply_bytes[k], k == reply_bytes.size() - 1);
        end
        reply_bytes.delete();
    endtask

    // drop valid and let every owed beat drain, then wait out the quiet slack
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (decoded_beats.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // bits above the register width are dropped
        if (idx == CFG_EXPECTED_ID) cfg_id = value;
        else cfg_name_room = value[9:0];
    endtask

    // ------------------------------------------------------------------------
    // reply building
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_name_char();
        case ($urandom_range(9))
            0:       return CHR_DASH;
            1:       return 8'($urandom);
            2, 3:    return 8'("0" + $urandom_range(9));
            4:       return 8'("A" + $urandom_range(25));
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    // any byte that does not start a name, zero now and then
    function automatic logic [7:0] random_separator();
        logic [7:0] b;
        if ($urandom_range(5) == 0) return 8'h00;
        b = 8'($urandom);
        while (is_name_char(b)) b = 8'($urandom);
        return b;
    endfunction

    function automatic void put_header(input logic [15:0] id, input logic [15:0] qd,
                                       input logic [15:0] an);
        reply_bytes.push_back(id[15:8]);
        reply_bytes.push_back(id[7:0]);
        repeat (2) reply_bytes.push_back(8'($urandom));
        reply_bytes.push_back(qd[15:8]);
        reply_bytes.push_back(qd[7:0]);
        reply_bytes.push_back(an[15:8]);
        reply_bytes.push_back(an[7:0]);
        repeat (4) reply_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_question();
        repeat ($urandom_range(6)) reply_bytes.push_back(8'($urandom_range(1, 255)));
        reply_bytes.push_back(8'h00);
        repeat (QFIXED_LEN) reply_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_answer_name(input t_answer_form form);
        case (form)
            AN_POINTER: begin
                reply_bytes.push_back(8'($urandom) | PTR_MASK);
                reply_bytes.push_back(8'($urandom));
            end
            AN_LABELS: begin
                // first byte nonzero and not a pointer
                reply_bytes.push_back(8'($urandom_range(1, 8'hBF)));
                repeat ($urandom_range(8)) reply_bytes.push_back(8'($urandom_range(1, 255)));
                reply_bytes.push_back(8'h00);
            end
            default: reply_bytes.push_back(8'h00);
        endcase
    endfunction

    function automatic void put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) rdata_bytes.push_back(s[k]);
    endfunction

    // type, class, ttl and rdlength, then the pending rdata
    function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                       input int rdlen_adjust);
        logic [15:0] rdlen;
        int k;
        rdlen = 16'(rdata_bytes.size() + rdlen_adjust);
        reply_bytes.push_back(rtype[15:8]);
        reply_bytes.push_back(rtype[7:0]);
        reply_bytes.push_back(rclass[15:8]);
        reply_bytes.push_back(rclass[7:0]);
        repeat (4) reply_bytes.push_back(8'($urandom));
        reply_bytes.push_back(rdlen[15:8]);
        reply_bytes.push_back(rdlen[7:0]);
        for (k = 0; k < rdata_bytes.size(); k++) reply_bytes.push_back(rdata_bytes[k]);
        rdata_bytes.delete();
    endfunction

    // well-formed ptr reply around the pending rdata
    task automatic send_ptr(input t_answer_form form, input int nq, input int rdlen_adjust);
        put_header(cfg_id, 16'(nq), 16'h0001);
        repeat (nq) put_question();
        put_answer_name(form);
        put_record(RR_TYPE_PTR, RR_CLASS_IN, rdlen_adjust);
        send_reply();
    endtask

    // reverse-lookup style name: junk lead, labels with length bytes, tail
    function automatic void put_random_rdata();
        repeat ($urandom_range(3)) rdata_bytes.push_back(random_separator());
        repeat ($urandom_range(6)) begin
            rdata_bytes.push_back(8'($urandom_range(1, 7)));
            repeat ($urandom_range(1, 7)) rdata_bytes.push_back(random_name_char());
        end
        if ($urandom_range(3) != 0) rdata_bytes.push_back(8'h00);
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 4)) rdata_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic send_random_reply();
        int          pick;
        int          nq;
        int          adjust;
        logic [15:0] an;
        logic [15:0] rtype;
        logic [15:0] rclass;
        pick = $urandom_range(99);
        nq   = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : $urandom_range(1);
        an   = $urandom_range(1) ? 16'($urandom_range(1, 255)) : 16'($urandom_range(1, 65535));
        if (pick < 4) begin
            // cut inside the header
            repeat ($urandom_range(1, HDR_LAST)) reply_bytes.push_back(8'($urandom));
        end else if (pick < 8) begin
            // line noise
            repeat ($urandom_range(12, 40)) reply_bytes.push_back(8'($urandom));
        end else begin
            put_header(pick < 12 ? cfg_id ^ 16'($urandom_range(1, 65535)) : cfg_id,
                       16'(nq), pick < 16 ? 16'h0000 : an);
            repeat (nq) put_question();
            put_answer_name(t_answer_form'($urandom_range(2)));
            put_random_rdata();
            if (pick < 22) begin
                // some other record kind
                rtype  = RR_TYPE_PTR;
                rclass = RR_CLASS_IN;
                case ($urandom_range(2))
                    0:       rtype = 16'($urandom);
                    1:       rclass = 16'($urandom);
                    default: begin
                        rtype  = 16'($urandom);
                        rclass = 16'($urandom);
                    end
                endcase
                put_record(rtype, rclass, 0);
            end else begin
                case ($urandom_range(9))
                    7:       adjust = -$urandom_range(rdata_bytes.size());
                    8:       adjust = $urandom_range(1, 3);
                    9:       adjust = -rdata_bytes.size();
                    default: adjust = 0;
                endcase
                put_record(RR_TYPE_PTR, RR_CLASS_IN, adjust);
            end
            // truncated anywhere in the reply
            if (pick >= 22 && pick < 28) begin
                adjust = $urandom_range(1, reply_bytes.size());
                while (reply_bytes.size() > adjust) void'(reply_bytes.pop_back());
            end
        end
        send_reply();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_header_checks();
        // short replies, one of them a lone byte
        repeat (5) reply_bytes.push_back(8'h00);
        send_reply();
        reply_bytes.push_back(8'hFF);
        send_reply();
        write_reg(CFG_EXPECTED_ID, 16'hFFFF);
        // id off by one bit
        put_header(16'hFFFE, 16'h0000, 16'h0001);
        put_answer_name(AN_POINTER);
        put_text("ab");
        put_record(RR_TYPE_PTR, RR_CLASS_IN, 0);
        send_reply();
        // no answers
        put_header(cfg_id, 16'h0000, 16'h0000);
        put_answer_name(AN_POINTER);
        put_text("ab");
        put_record(RR_TYPE_PTR, RR_CLASS_IN, 0);
        send_reply();
        // answer count only in its high byte
        put_header(cfg_id, 16'h0000, 16'h0100);
        put_answer_name(AN_POINTER);
        put_text("z");
        put_record(RR_TYPE_PTR, RR_CLASS_IN, 0);
        send_reply();
        // huge question count, reply ends among the questions
        put_header(cfg_id, 16'hFFFF, 16'h0001);
        repeat (2) put_question();
        send_reply();
    endtask

    task automatic test_answer_names();
        put_text("host1");
        send_ptr(AN_LABELS, 2, 0);
        put_text("a-b");
        send_ptr(AN_ROOT, 1, 0);
        // ends right after rdlength
        send_ptr(AN_POINTER, 0, 0);
    endtask

    task automatic test_name_forming();
        // junk lead, separators to dots, dash kept, high byte to dot
        rdata_bytes.push_back(8'h00);
        rdata_bytes.push_back(8'h03);
        rdata_bytes.push_back(8'hFF);
        put_text("ab");
        rdata_bytes.push_back(8'h01);
        put_text("c-d");
        rdata_bytes.push_back(8'h80);
        put_text("e");
        rdata_bytes.push_back(8'h00);
        send_ptr(AN_POINTER, 0, 0);
        // rdlength runs out, later bytes go out unchanged
        put_text("ab");
        rdata_bytes.push_back(8'h05);
        put_text("c.");
        send_ptr(AN_ROOT, 0, -3);
        // zero rdlength wraps on the junk lead
        put_text(".a/b");
        send_ptr(AN_POINTER, 0, -4);
        // nothing name-like at all
        rdata_bytes.push_back(8'h01);
        rdata_bytes.push_back(8'h02);
        rdata_bytes.push_back(8'h00);
        rdata_bytes.push_back(8'hFF);
        send_ptr(AN_POINTER, 0, 0);
        // fewer rdata bytes than rdlength
        put_text("abc");
        send_ptr(AN_POINTER, 0, 5);
        // small buffer: name too long, fits, junk lead too long
        write_reg(CFG_NAME_BUF_SZ, {6'($urandom), 10'd3});
        put_text("abc");
        send_ptr(AN_POINTER, 0, 0);
        put_text("ab");
        send_ptr(AN_POINTER, 0, 0);
        rdata_bytes.push_back(8'h01);
        rdata_bytes.push_back(8'h01);
        put_text("ab");
        send_ptr(AN_POINTER, 0, 0);
        // one-byte buffer only takes the empty name
        write_reg(CFG_NAME_BUF_SZ, {6'($urandom), 10'd1});
        rdata_bytes.push_back(8'h00);
        send_ptr(AN_POINTER, 0, 0);
        put_text("q");
        send_ptr(AN_POINTER, 0, 0);
    endtask

    task automatic test_bad_record();
        put_text("ab");
        put_header(cfg_id, 16'h0000, 16'h0001);
        put_answer_name(AN_POINTER);
        put_record(16'h0001, RR_CLASS_IN, 0);
        send_reply();
        put_text("ab");
        put_header(cfg_id, 16'h0000, 16'h0001);
        put_answer_name(AN_ROOT);
        put_record(RR_TYPE_PTR, 16'hFFFF, 0);
        send_reply();
        put_text("ab");
        put_header(cfg_id, 16'h0000, 16'h0001);
        put_answer_name(AN_LABELS);
        put_record(16'hFFFF, RR_CLASS_IN, 0);
        send_reply();
    endtask

    // name runs exactly to the byte limit; bytes beyond it are dropped
    task automatic test_overlong();
        write_reg(CFG_NAME_BUF_SZ, {6'($urandom), 10'd512});
        repeat (488 + 40) rdata_bytes.push_back(8'("a" + $urandom_range(25)));
        send_ptr(AN_POINTER, 0, -40);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [15:0] id, input logic [9:0] room);
        int unsigned stop_at;
        write_reg(CFG_EXPECTED_ID, id);
        write_reg(CFG_NAME_BUF_SZ, {6'($urandom), room});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at) send_random_reply();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 16'($urandom), 10'd512);
        run_random_phase(47, 0, 16'h0000, 10'($urandom_range(4, 48)));
        run_random_phase(0, 47, 16'hFFFF, NAME_BUF_RST);
        run_random_phase(30, 30, 16'($urandom), 10'($urandom_range(8, 40)));
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_parser_mirror();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_checks();
        test_answer_names();
        test_name_forming();
        test_bad_record();
        test_overlong();
        test_random_traffic();
        wait_quiet();
        if (mismatch_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
design/dpr_pkg.sv
design/dns_ptr_response_parser.sv
design/dpr_checker.sv
verif/testbench.sv
